// ===== src/hslh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hslh_pkg
// types, constants and codes shared by the hsl histogram signature block
// ----------------------------------------------------------------------------
package hslh_pkg;

    localparam int BIN_COUNT_DEF = 16;
    localparam int MAX_SIDE_DEF  = 4096;
    localparam int COUNT_W       = 21;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [1:0] KIND_HUE        = 2'd0;
    localparam logic [1:0] KIND_SATURATION = 2'd1;
    localparam logic [1:0] KIND_LIGHTNESS  = 2'd2;
    localparam logic [1:0] KIND_MEDIAN     = 2'd3;

    localparam logic ADDR_FRAME_WIDTH  = 1'b0;
    localparam logic ADDR_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] first_channel;
        logic [7:0] second_channel;
        logic [7:0] third_channel;
    } pixel_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [3:0]         bin_index;
        logic [COUNT_W-1:0] bin_count;
        logic               region_empty;
        logic               last_result;
    } result_t;

    // divider request and response between the top level and the shared unit
    typedef struct packed {
        logic        start;
        logic [19:0] dividend;
        logic [11:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [19:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== src/hslh_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hslh_divider
// restoring divider, one quotient bit per cycle, shared by all quotients
// ----------------------------------------------------------------------------
module hslh_divider
    import hslh_pkg::*;
(
    input  wire           clk,
    input  wire           rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [19:0] quot_reg, quot_next;
    logic [11:0] div_reg, div_next;
    logic [12:0] rem_reg, rem_next;
    logic [4:0]  count_reg, count_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;
    logic [13:0] diff;

    always_comb
    begin
        quot_next  = quot_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg[11:0], quot_reg[19]};
        diff       = {1'b0, trial} - {2'b00, div_reg};
        if (req.start)
        begin
            quot_next  = req.dividend;
            div_next   = req.divisor;
            rem_next   = '0;
            count_next = 5'd20;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[13])
            begin
                rem_next  = diff[12:0];
                quot_next = {quot_reg[18:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[18:0], 1'b0};
            end
            count_next = count_reg - 5'd1;
            if (count_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

`default_nettype wire

// ===== src/hsl_center_histogram_signature_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsl_center_histogram_signature_core
// rgb to hsl conversion and centre-region histograms with a frame signature
// ----------------------------------------------------------------------------
// a gray pixel goes straight from the lightness state to the bump; others wait on
// two 20-step passes of the shared divider (saturation, then hue)
// frame end: 48 bin requests at one per cycle when the receiver is ready, an 8-pass
// min-scan median and one median request (an empty centre gives one empty request
// instead), then a clear of all 16 bins; reset is asynchronous, active low: sizes
// go to 640x480, counters and histograms to zero
module hsl_center_histogram_signature_core
    import hslh_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF,
    parameter int MAX_SIDE  = MAX_SIDE_DEF
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire pixel_t in_data,
    output logic        out_valid,
    input  wire         out_ready,
    output result_t     out_data
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int BIN_W  = $clog2(BIN_COUNT);

    typedef enum logic [3:0] {
        S_IDLE, S_LDIV, S_SDIV, S_HDIV, S_BUMP, S_EMIT, S_MED, S_MOUT,
        S_EMPTY, S_CLEAR
    } state_t;

    state_t state_reg;
    logic [12:0] fw_reg, fh_reg;
    logic [POS_W-1:0] col_reg, row_reg;
    logic [COUNT_W-1:0] hist_h_reg [BIN_COUNT];
    logic [COUNT_W-1:0] hist_s_reg [BIN_COUNT];
    logic [COUNT_W-1:0] hist_l_reg [BIN_COUNT];
    logic [7:0] r_reg, g_reg, b_reg, h_reg, s_reg, l_reg;
    logic inside_reg;
    logic [BIN_W+1:0] idx_reg;
    logic [BIN_W-1:0] pass_reg, scan_reg, minpos_reg;
    logic [COUNT_W-1:0] min_reg;
    logic [BIN_COUNT-1:0] used_reg;
    logic first_reg;
    result_t out_reg;
    logic out_valid_reg;
    div_req_t dreq;
    div_rsp_t drsp;

    hslh_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // effective sizes and centre window
    logic [SIDE_W-1:0] w_eff, h_eff, x0, y0;
    always_comb
    begin
        w_eff = (fw_reg == 13'd0) ? SIDE_W'(1)
              : (32'(fw_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(fw_reg);
        h_eff = (fh_reg == 13'd0) ? SIDE_W'(1)
              : (32'(fh_reg) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(fh_reg);
        // divide by three as a multiply by 2^16/3, exact below 2^15
        x0 = SIDE_W'((32'(w_eff) * 32'd21846) >> 16);
        y0 = SIDE_W'((32'(h_eff) * 32'd21846) >> 16);
    end

    // pixel operands
    logic [7:0] mx, mn;
    logic [8:0] dd, sum;
    logic [11:0] nn;
    logic [15:0] lt;
    logic [16:0] lq;
    always_comb
    begin
        mx = r_reg;
        mn = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        dd  = {1'b0, mx} - {1'b0, mn};
        sum = {1'b0, mx} + {1'b0, mn};
        if (r_reg == mx)
            nn = (g_reg >= b_reg) ? 12'(g_reg - b_reg)
                                  : 12'(6 * dd) - 12'(b_reg - g_reg);
        else if (g_reg == mx)
            nn = 12'(2 * dd) + 12'(b_reg) - 12'(r_reg);
        else
            nn = 12'(4 * dd) + 12'(r_reg) - 12'(g_reg);
        // lightness: 128 * sum / 255 as (v + v/256 + 1) / 256, exact for 16-bit v
        lt = {sum, 7'd0};
        lq = 17'(lt) + 17'(lt[15:8]) + 17'd1;
    end

    logic wr;
    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_FRAME_HEIGHT) ? {19'd0, fh_reg} : {19'd0, fw_reg};

    logic bump_s_inc, bump_h_inc, bump_l_inc;
    logic [BIN_W-1:0] hb, sb, lb;
    assign hb = h_reg[7:8-BIN_W];
    assign sb = s_reg[7:8-BIN_W];
    assign lb = l_reg[7:8-BIN_W];
    assign bump_h_inc = hist_h_reg[hb] != COUNT_MAX;
    assign bump_s_inc = hist_s_reg[sb] != COUNT_MAX;
    assign bump_l_inc = hist_l_reg[lb] != COUNT_MAX;

    logic [BIN_W-1:0] ei;
    assign ei = idx_reg[BIN_W-1:0];

    logic take_min;
    assign take_min = !used_reg[scan_reg] && (first_reg || hist_h_reg[scan_reg] < min_reg);

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = '0;
        dreq.divisor  = '0;
        if (state_reg == S_LDIV && dd != 9'd0)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = 20'({dd, 8'd0});
            dreq.divisor  = (sum <= 9'd255) ? 12'(sum) : 12'(10'd510 - 10'(sum));
        end
        if (state_reg == S_SDIV && drsp.done)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = 20'({nn, 8'd0});
            dreq.divisor  = 12'(6 * dd);
        end
    end

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fw_reg        <= 13'd640;
            fh_reg        <= 13'd480;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            idx_reg       <= '0;
            r_reg         <= '0;
            g_reg         <= '0;
            b_reg         <= '0;
            h_reg         <= '0;
            s_reg         <= '0;
            l_reg         <= '0;
            inside_reg    <= 1'b0;
            pass_reg      <= '0;
            scan_reg      <= '0;
            minpos_reg    <= '0;
            min_reg       <= '0;
            used_reg      <= '0;
            first_reg     <= 1'b0;
            for (int i = 0; i < BIN_COUNT; i++)
            begin
                hist_h_reg[i] <= '0;
                hist_s_reg[i] <= '0;
                hist_l_reg[i] <= '0;
            end
        end
        else
        begin
            if (wr && paddr[2] == ADDR_FRAME_WIDTH && paddr[1:0] == 2'd0)
                fw_reg <= pwdata[12:0];
            if (wr && paddr[2] == ADDR_FRAME_HEIGHT && paddr[1:0] == 2'd0)
                fh_reg <= pwdata[12:0];
            if (out_free)
                out_valid_reg <= state_reg == S_EMIT || state_reg == S_MOUT
                              || state_reg == S_EMPTY;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        r_reg <= in_data.first_channel;
                        g_reg <= in_data.second_channel;
                        b_reg <= in_data.third_channel;
                        state_reg <= S_LDIV;
                    end
                end
                S_LDIV:
                begin
                    l_reg <= lq[15:8];
                    inside_reg <= SIDE_W'(col_reg) >= x0 && SIDE_W'(col_reg) < 2 * x0
                               && SIDE_W'(row_reg) >= y0 && SIDE_W'(row_reg) < 2 * y0;
                    if (dd == 9'd0)
                    begin
                        h_reg <= '0;
                        s_reg <= '0;
                        state_reg <= S_BUMP;
                    end
                    else
                        state_reg <= S_SDIV;
                end
                S_SDIV:
                begin
                    if (drsp.done)
                    begin
                        s_reg <= drsp.quotient[7:0];
                        state_reg <= S_HDIV;
                    end
                end
                S_HDIV:
                begin
                    if (drsp.done)
                    begin
                        h_reg <= drsp.quotient[7:0];
                        state_reg <= S_BUMP;
                    end
                end
                S_BUMP:
                begin
                    if (inside_reg)
                    begin
                        if (bump_h_inc) hist_h_reg[hb] <= hist_h_reg[hb] + 1'b1;
                        if (bump_s_inc) hist_s_reg[sb] <= hist_s_reg[sb] + 1'b1;
                        if (bump_l_inc) hist_l_reg[lb] <= hist_l_reg[lb] + 1'b1;
                    end
                    if (SIDE_W'(col_reg) + 1'b1 < w_eff)
                    begin
                        col_reg <= col_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        col_reg <= '0;
                        if (SIDE_W'(row_reg) + 1'b1 < h_eff)
                        begin
                            row_reg <= row_reg + 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            row_reg <= '0;
                            idx_reg <= '0;
                            state_reg <= (x0 == '0 || y0 == '0) ? S_EMPTY : S_EMIT;
                        end
                    end
                end
                S_EMPTY:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{KIND_HUE, 4'd0, '0, 1'b1, 1'b1};
                        idx_reg <= '0;
                        state_reg <= S_CLEAR;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg.bin_index    <= 4'(ei);
                        out_reg.region_empty <= 1'b0;
                        out_reg.last_result  <= 1'b0;
                        case (idx_reg[BIN_W+1:BIN_W])
                            2'd0:
                            begin
                                out_reg.result_kind <= KIND_HUE;
                                out_reg.bin_count   <= hist_h_reg[ei];
                            end
                            2'd1:
                            begin
                                out_reg.result_kind <= KIND_SATURATION;
                                out_reg.bin_count   <= hist_s_reg[ei];
                            end
                            default:
                            begin
                                out_reg.result_kind <= KIND_LIGHTNESS;
                                out_reg.bin_count   <= hist_l_reg[ei];
                            end
                        endcase
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == (BIN_W+2)'(3 * BIN_COUNT - 1))
                        begin
                            state_reg  <= S_MED;
                            pass_reg   <= '0;
                            scan_reg   <= '0;
                            used_reg   <= '0;
                            first_reg  <= 1'b1;
                        end
                    end
                end
                S_MED:
                begin
                    // one pass per rank: scan for the smallest unused bin
                    if (take_min)
                    begin
                        min_reg    <= hist_h_reg[scan_reg];
                        minpos_reg <= scan_reg;
                    end
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == BIN_W'(BIN_COUNT - 1))
                    begin
                        if (pass_reg == BIN_W'(BIN_COUNT / 2 - 1))
                            state_reg <= S_MOUT;
                        else
                        begin
                            pass_reg  <= pass_reg + 1'b1;
                            first_reg <= 1'b1;
                            if (take_min)
                                used_reg[scan_reg] <= 1'b1;
                            else
                                used_reg[minpos_reg] <= 1'b1;
                        end
                    end
                    else if (take_min)
                        first_reg <= 1'b0;
                end
                S_MOUT:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{KIND_MEDIAN, 4'd0,
                                     (min_reg == '0) ? COUNT_W'(1) : min_reg, 1'b0, 1'b1};
                        idx_reg <= '0;
                        state_reg <= S_CLEAR;
                    end
                end
                S_CLEAR:
                begin
                    hist_h_reg[ei] <= '0;
                    hist_s_reg[ei] <= '0;
                    hist_l_reg[ei] <= '0;
                    idx_reg <= idx_reg + 1'b1;
                    if (ei == BIN_W'(BIN_COUNT - 1))
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/hslh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hslh_checker
// port-level checks on the histogram signature block
// ----------------------------------------------------------------------------
module hslh_checker
    import hslh_pkg::*;
(
    input wire          clk,
    input wire          rst_n,
    input wire          in_valid,
    input wire          in_ready,
    input wire          out_valid,
    input wire          out_ready,
    input wire result_t out_data
);

    // an accepted pixel keeps the block busy next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a pixel request");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // the empty flag comes only on a last result
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.region_empty |-> out_data.last_result)
        else $error("empty flag without last");

    // median result is always last
    a_med: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_MEDIAN |-> out_data.last_result)
        else $error("median not last");

endmodule

bind hsl_center_histogram_signature_core hslh_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

`default_nettype wire

// ===== verif/hsl_center_histogram_signature_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_center_histogram_signature_core_tb
// drives raster pixels through the block over several frame sizes, predicts
// the hue, saturation and lightness histograms of the centre third and checks
// every bin, median and empty-region request in order
// ----------------------------------------------------------------------------
module hsl_center_histogram_signature_core_tb
    import hslh_pkg::*;
();

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    pixel_t      in_data;
    logic        out_valid;
    logic        out_ready;
    result_t     out_data;

    // predicted state
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    int unsigned col_pos;
    int unsigned row_pos;
    logic [20:0] hue_bins [16];
    logic [20:0] sat_bins [16];
    logic [20:0] light_bins [16];

    result_t     expected_results [$];
    int          error_count;
    int          frames_seen;
    int          pixels_sent;
    int          idle_cycles;
    bit          hold_receiver;

    hsl_center_histogram_signature_core u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_side(logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE_DEF)
            return MAX_SIDE_DEF;
        return v;
    endfunction

    task automatic compute_hsl(input pixel_t p, output logic [7:0] h, output logic [7:0] s,
                               output logic [7:0] l);
        int unsigned r, g, b, mx, mn, d, sum, n;
        r = p.first_channel;
        g = p.second_channel;
        b = p.third_channel;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sum = mx + mn;
        l = 8'((sum * 128) / 255);
        if (d == 0)
        begin
            h = 0;
            s = 0;
        end
        else
        begin
            if (sum <= 255)
                s = 8'((256 * d) / sum);
            else
                s = 8'((256 * d) / (510 - sum));
            if (r == mx)
                n = (g >= b) ? (g - b) : (6 * d - (b - g));
            else if (g == mx)
                n = 2 * d + b - r;
            else
                n = 4 * d + r - g;
            h = 8'((256 * n) / (6 * d));
        end
    endtask

    function automatic logic [20:0] eighth_smallest_hue();
        logic [20:0] sorted [16];
        logic [20:0] t;
        for (int i = 0; i < 16; i++)
            sorted[i] = hue_bins[i];
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 15 - i; j++)
                if (sorted[j] > sorted[j+1])
                begin
                    t = sorted[j];
                    sorted[j] = sorted[j+1];
                    sorted[j+1] = t;
                end
        return sorted[7] == 0 ? 21'd1 : sorted[7];
    endfunction

    function automatic result_t make_result(logic [1:0] k, logic [3:0] i, logic [20:0] c,
                                            logic e, logic last);
        result_t r;
        r.result_kind = k;
        r.bin_index = i;
        r.bin_count = c;
        r.region_empty = e;
        r.last_result = last;
        return r;
    endfunction

    task automatic predict_pixel(input pixel_t p);
        int unsigned w, ht, x0, y0;
        logic [7:0] h, s, l;
        w = eff_side(width_reg);
        ht = eff_side(height_reg);
        x0 = w / 3;
        y0 = ht / 3;
        compute_hsl(p, h, s, l);
        if (col_pos >= x0 && col_pos < 2 * x0 && row_pos >= y0 && row_pos < 2 * y0)
        begin
            if (hue_bins[h[7:4]] != COUNT_MAX) hue_bins[h[7:4]]++;
            if (sat_bins[s[7:4]] != COUNT_MAX) sat_bins[s[7:4]]++;
            if (light_bins[l[7:4]] != COUNT_MAX) light_bins[l[7:4]]++;
        end
        if (col_pos + 1 < w)
        begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (row_pos + 1 < ht)
        begin
            row_pos++;
            return;
        end
        row_pos = 0;
        if (x0 == 0 || y0 == 0)
            expected_results.push_back(make_result(KIND_HUE, 0, 0, 1, 1));
        else
        begin
            for (int i = 0; i < 16; i++)
                expected_results.push_back(make_result(KIND_HUE, 4'(i), hue_bins[i], 0, 0));
            for (int i = 0; i < 16; i++)
                expected_results.push_back(make_result(KIND_SATURATION, 4'(i), sat_bins[i],
                                                       0, 0));
            for (int i = 0; i < 16; i++)
                expected_results.push_back(make_result(KIND_LIGHTNESS, 4'(i), light_bins[i],
                                                       0, 0));
            expected_results.push_back(make_result(KIND_MEDIAN, 0, eighth_smallest_hue(), 0, 1));
        end
        for (int i = 0; i < 16; i++)
        begin
            hue_bins[i] = 0;
            sat_bins[i] = 0;
            light_bins[i] = 0;
        end
    endtask

    // valid stays up after a request until a gap or a drain drops it
    task automatic send_pixel(input pixel_t p, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pixel(p);
        pixels_sent++;
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = pixel_t'($urandom);
        case ($urandom_range(0, 5))
            0: p.second_channel = p.first_channel;
            1: p.third_channel = p.second_channel;
            2: p = '{8'hff, 8'hff, 8'hff};
            default: ;
        endcase
        return p;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        // a pixel may still be in the divider or the clear sweep may be running
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ADDR_FRAME_WIDTH)
            width_reg = value[12:0];
        else
            height_reg = value[12:0];
    endtask

    task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
        write_reg(ADDR_FRAME_WIDTH, w);
        write_reg(ADDR_FRAME_HEIGHT, h);
    endtask

    task automatic send_frames(input int count);
        int total;
        total = eff_side(width_reg) * eff_side(height_reg) * count;
        for (int i = 0; i < total; i++)
            send_pixel(random_pixel(), 1'b0);
    endtask

    // directed corners inside a 9x3 frame whose centre is columns 3..5 of row 1
    task automatic test_directed_corners();
        pixel_t corners [9];
        corners = '{'{8'hff, 8'hff, 8'hff}, '{8'h00, 8'h00, 8'h00}, '{8'hff, 8'h00, 8'h00},
                    '{8'h00, 8'hff, 8'h00}, '{8'h00, 8'h00, 8'hff}, '{8'hff, 8'h00, 8'hff},
                    '{8'h80, 8'h00, 8'h00}, '{8'hff, 8'hff, 8'h00}, '{8'h7f, 8'h80, 8'h7f}};
        set_frame(9, 3);
        for (int i = 0; i < 27; i++)
            send_pixel(i < 9 ? corners[i] : corners[(i * 4) % 9], 1'b0);
        wait_drained();
    endtask

    // widths and heights below three leave the centre empty; zero acts as one
    task automatic test_empty_region();
        set_frame(0, 0);
        send_frames(3);
        wait_drained();
        set_frame(2, 5);
        send_frames(1);
        wait_drained();
        set_frame(5, 1);
        send_frames(1);
        wait_drained();
    endtask

    // sizes above the maximum saturate; only a short row is sent before the change
    task automatic test_size_saturation();
        set_frame(32'h1fff, 3);
        repeat (6) send_pixel(random_pixel(), 1'b0);
        wait_drained();
        set_frame(3, 3);
        repeat (3) send_pixel(random_pixel(), 1'b0);
        wait_drained();
    endtask

    // long receiver hold while pixels keep coming, to back up the block
    task automatic test_backpressure();
        set_frame(3, 3);
        hold_receiver = 1'b1;
        for (int i = 0; i < 18; i++)
            send_pixel(random_pixel(), 1'b1);
        hold_receiver = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_frames();
        int w, h;
        while (pixels_sent < 340)
        begin
            w = $urandom_range(3, 8);
            h = $urandom_range(3, 6);
            set_frame(w, h);
            send_frames(1);
            wait_drained();
        end
    endtask

    // result checker with random receiver stalls
    initial
    begin
        result_t exp_r;
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (hold_receiver)
            begin
                stall = 600;
                hold_receiver = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected request expected none actual %p", $time, out_data);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_data !== exp_r)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, exp_r, out_data);
                    error_count++;
                end
                if (exp_r.last_result)
                    frames_seen++;
            end
        end
    end

    // watchdog on cycles without any request
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_data = '0;
        error_count = 0;
        frames_seen = 0;
        pixels_sent = 0;
        idle_cycles = 0;
        hold_receiver = 1'b0;
        width_reg = 13'd640;
        height_reg = 13'd480;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 16; i++)
        begin
            hue_bins[i] = 0;
            sat_bins[i] = 0;
            light_bins[i] = 0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (40) @(posedge clk);

        test_directed_corners();
        test_empty_region();
        test_size_saturation();
        test_backpressure();
        test_random_frames();
        wait_drained();

        $display("covered %0d pixels over %0d frames, including empty centres,", pixels_sent,
                 frames_seen);
        $display("saturated and zero sizes, white and pure hues, and output backpressure");
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
